FILE: design/pwmcm_pkg.sv
// Shared types and constants for the PWM channel manager.
`default_nettype none

package pwmcm_pkg;

    localparam int FUNC_W   = 3;
    localparam int PIN_W    = 2;
    localparam int FREQ_W   = 16;
    localparam int PCT_W    = 7;
    localparam int STATUS_W = 3;
    localparam int TOP_W    = 8;
    localparam int IDX_W    = 5;
    localparam int DUTY_W   = 8;
    localparam int NUM_CH   = 2;

    // fastest timer clock, 64 MHz; 32 MHz is that quotient halved
    localparam int Q64_W = 26;
    localparam logic [Q64_W-1:0] CLK_FAST_HZ = 26'd64000000;

    // duty = pct * 256 / 100
    localparam int DUTY_DVD_W = PCT_W + 8;
    localparam int DUTY_DVS_W = 7;
    localparam logic [DUTY_DVS_W-1:0] DUTY_DIVISOR = 7'd100;

    localparam logic [IDX_W-1:0] IDX_FAST = 5'd0;
    localparam logic [IDX_W-1:0] IDX_HALF = 5'd1;
    localparam logic [IDX_W-1:0] IDX_CPU  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_LAST = 5'd16;

    // largest quotient that still gives an 8-bit top
    localparam logic [Q64_W-1:0] Q_MAX = 26'd256;

    localparam logic [FUNC_W-1:0] FN_INIT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLAIM   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREQ    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DUTY    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNCLAIM = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNINIT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_PIN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IN_USE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_FREQ = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DONE
    } state_t;

    // clock search result handed from the scanner to the control
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [TOP_W-1:0] top;
    } sel_res_t;

endpackage

`default_nettype wire

FILE: design/pwmcm_if.sv
// Command and response channel interfaces.
`default_nettype none

interface pwmcm_cmd_if import pwmcm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PIN_W-1:0]  pin;
    logic [FREQ_W-1:0] freq_hz;
    logic [PCT_W-1:0]  duty_pct;

    modport source (output valid, func, pin, freq_hz, duty_pct, input ready);
    modport sink   (input valid, func, pin, freq_hz, duty_pct, output ready);
endinterface

interface pwmcm_rsp_if import pwmcm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                channel;
    logic [TOP_W-1:0]    top;
    logic [IDX_W-1:0]    clock_sel;
    logic [DUTY_W-1:0]   duty_level;
    logic [NUM_CH-1:0]   active_mask;
    logic                clock_running;

    modport source (output valid, status, channel, top, clock_sel, duty_level,
                    active_mask, clock_running, input ready);
    modport sink   (input valid, status, channel, top, clock_sel, duty_level,
                    active_mask, clock_running, output ready);
endinterface

`default_nettype wire

FILE: design/pwm_channel_manager_prescaler_select.sv
// Top level: two-channel PWM timer manager with prescaler and top selection.
//
//  channel | dir | payload                                               | handshake
//  --------+-----+-------------------------------------------------------+------------
//  cmd     | in  | func, pin, freq_hz, duty_pct                          | valid/ready
//  rsp     | out | status, channel, top, clock_sel, duty_level,          | valid/ready
//          |     | active_mask, clock_running                            |
//
// One command at a time. From accept to result, the 26-bit serial divide of 64 MHz
// by freq_hz (one bit a cycle) comes first and takes the longest; then the search
// starts and tries the timer clocks in list order (index 0 to 16), the state
// machine enters the done state and the result register is written.
// The next command is taken as soon as the result appears.
// Reset clears the control state: not initialized, no channel claimed, clock stopped.
// The result sits in an output register; a new command is taken while it waits,
// and the next result is held back until the previous one has been taken.
`default_nettype none

module pwm_channel_manager_prescaler_select import pwmcm_pkg::*; #(
    parameter int CPU_HZ = 8000000
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pwmcm_cmd_if.sink    cmd,
    pwmcm_rsp_if.source  rsp
);

    localparam int CPU_W = $clog2(CPU_HZ + 1);

    // control and state registers
    state_t              state_reg, state_next;
    logic                ready_flag_reg, ready_flag_next;
    logic [NUM_CH-1:0]   claimed_reg, claimed_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [IDX_W-1:0]    clk_idx_reg, clk_idx_next;
    logic                running_reg, running_next;
    logic [DUTY_W-1:0]   duty_reg [NUM_CH];
    logic [DUTY_W-1:0]   duty_next [NUM_CH];

    // latched command
    logic [FUNC_W-1:0]   func_reg;
    logic [PIN_W-1:0]    pin_reg;
    logic                freq_zero_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_channel_reg;
    logic [TOP_W-1:0]    out_top_reg;
    logic [IDX_W-1:0]    out_clk_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [NUM_CH-1:0]   out_mask_reg;
    logic                out_run_reg;

    // datapath
    logic                      accept;
    logic                      commit;
    logic                      scan_start;
    logic                      div_fast_busy, div_cpu_busy, div_duty_busy;
    logic [Q64_W-1:0]          q_fast;
    logic [CPU_W-1:0]          q_cpu;
    logic [DUTY_DVD_W-1:0]     q_duty;
    logic                      scan_busy;
    sel_res_t                  sel_res;
    logic                      ch;
    logic                      pin_ok;
    logic                      freq_ok;
    logic [DUTY_W-1:0]         duty_val;
    logic [STATUS_W-1:0]       status;

    assign accept = cmd.valid && cmd.ready;

    // Three serial dividers run side by side: 64 MHz / freq, CPU clock / freq,
    // and percent * 256 / 100 for the duty level.
    pwmcm_div #(
        .DVD_W (Q64_W),
        .DVS_W (FREQ_W)
    ) u_div_fast (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (CLK_FAST_HZ),
        .divisor  (cmd.freq_hz),
        .busy     (div_fast_busy),
        .quotient (q_fast)
    );

    pwmcm_div #(
        .DVD_W (CPU_W),
        .DVS_W (FREQ_W)
    ) u_div_cpu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (CPU_W'(CPU_HZ)),
        .divisor  (cmd.freq_hz),
        .busy     (div_cpu_busy),
        .quotient (q_cpu)
    );

    pwmcm_div #(
        .DVD_W (DUTY_DVD_W),
        .DVS_W (DUTY_DVS_W)
    ) u_div_duty (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend ({cmd.duty_pct, 8'd0}),
        .divisor  (DUTY_DIVISOR),
        .busy     (div_duty_busy),
        .quotient (q_duty)
    );

    // Clock search: 64 MHz, 32 MHz (fast quotient halved), then CPU >> 0..14.
    pwmcm_scan #(
        .QC_W (CPU_W)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .q_fast (q_fast),
        .q_cpu  (q_cpu),
        .busy   (scan_busy),
        .res    (sel_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_fast_busy && !div_cpu_busy && !div_duty_busy)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!scan_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state machine outputs
    always_comb
    begin
        cmd.ready  = 1'b0;
        scan_start = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            S_DIV:
            begin
                scan_start = !div_fast_busy && !div_cpu_busy && !div_duty_busy;
            end
            S_SCAN:
            begin
            end
            S_DONE:
            begin
                commit = !out_valid_reg || rsp.ready;
            end
            default:
            begin
            end
        endcase
    end

    // Command decode. Pins 2 and 3 have no timer channel: they get a bad-pin status and report channel 0.
    assign pin_ok   = !pin_reg[1];
    assign ch       = pin_reg[1] ? 1'b0 : pin_reg[0];
    assign freq_ok  = !freq_zero_reg && sel_res.ok;
    assign duty_val = (q_duty > DUTY_DVD_W'(8'hFF)) ? 8'hFF : q_duty[DUTY_W-1:0];

    always_comb
    begin
        status          = ST_OK;
        ready_flag_next = ready_flag_reg;
        claimed_next    = claimed_reg;
        top_next        = top_reg;
        clk_idx_next    = clk_idx_reg;
        running_next    = running_reg;
        duty_next       = duty_reg;

        case (func_reg) inside
            FN_INIT:
            begin
                ready_flag_next = 1'b1;
            end
            FN_CLAIM, FN_FREQ, FN_DUTY, FN_UNCLAIM:
            begin
                if (!ready_flag_reg)
                begin
                    status = ST_UNINIT;
                end
                else if (!pin_ok)
                begin
                    status = ST_BAD_PIN;
                end
                else if (func_reg == FN_CLAIM)
                begin
                    if (claimed_reg[ch])
                    begin
                        status = ST_IN_USE;
                    end
                    else if (!freq_ok)
                    begin
                        status = ST_BAD_FREQ;
                    end
                    else
                    begin
                        clk_idx_next     = sel_res.idx;
                        top_next         = sel_res.top;
                        running_next     = 1'b1;
                        duty_next[ch]    = duty_val;
                        claimed_next[ch] = 1'b1;
                    end
                end
                else if (!claimed_reg[ch])
                begin
                    status = ST_UNUSED;
                end
                else if (func_reg == FN_FREQ)
                begin
                    if (!freq_ok)
                    begin
                        status = ST_BAD_FREQ;
                    end
                    else
                    begin
                        clk_idx_next = sel_res.idx;
                        top_next     = sel_res.top;
                        running_next = 1'b1;
                    end
                end
                else if (func_reg == FN_DUTY)
                begin
                    duty_next[ch] = duty_val;
                end
                else
                begin
                    claimed_next[ch] = 1'b0;
                end
            end
            default:
            begin
                // unused codes answer ok and change nothing
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_flag_reg <= 1'b0;
            claimed_reg    <= '0;
            top_reg        <= '0;
            clk_idx_reg    <= '0;
            running_reg    <= 1'b0;
            duty_reg[0]    <= '0;
            duty_reg[1]    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                ready_flag_reg <= ready_flag_next;
                claimed_reg    <= claimed_next;
                top_reg        <= top_next;
                clk_idx_reg    <= clk_idx_next;
                running_reg    <= running_next;
                duty_reg       <= duty_next;
            end
        end
    end

    // command latch and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= cmd.func;
            pin_reg       <= cmd.pin;
            freq_zero_reg <= (cmd.freq_hz == '0);
        end
        if (commit)
        begin
            out_status_reg  <= status;
            out_channel_reg <= ch;
            out_top_reg     <= top_next;
            out_clk_reg     <= clk_idx_next;
            out_duty_reg    <= duty_next[ch];
            out_mask_reg    <= claimed_next;
            out_run_reg     <= running_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.channel       = out_channel_reg;
    assign rsp.top           = out_top_reg;
    assign rsp.clock_sel     = out_clk_reg;
    assign rsp.duty_level    = out_duty_reg;
    assign rsp.active_mask   = out_mask_reg;
    assign rsp.clock_running = out_run_reg;

    // top and clock index stay zero while the clock is stopped
    a_stopped_clock_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (top_reg == '0 && clk_idx_reg == '0))
        else $error("timer settings changed while clock stopped");

    // no claim can exist before init
    a_claim_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
        !ready_flag_reg |-> (claimed_reg == '0 && !running_reg))
        else $error("claim or clock state without init");

    // a failing command leaves the state alone
    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && status != ST_OK) |=>
            ($stable(claimed_reg) && $stable(top_reg) && $stable(clk_idx_reg)))
        else $error("state changed by a failing command");

    // a result is produced only from the done state
    a_commit_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (state_reg == S_DONE && !scan_busy))
        else $error("result written outside done state");

endmodule

`default_nettype wire

FILE: design/pwmcm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module pwmcm_div #(
    parameter int DVD_W = 26,
    parameter int DVS_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/pwmcm_scan.sv
// Timer clock search: walks the clock list, halving the quotient each step but the switch to the CPU clock.
`default_nettype none

module pwmcm_scan import pwmcm_pkg::*; #(
    parameter int QC_W = 23
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [Q64_W-1:0] q_fast,
    input  wire logic [QC_W-1:0]  q_cpu,
    output logic                  busy,
    output sel_res_t              res
);

    logic             busy_reg, busy_next;
    logic [Q64_W-1:0] cand_reg;
    logic [Q64_W-1:0] cand_dec;
    logic [IDX_W-1:0] idx_reg;
    logic [QC_W-1:0]  qc_reg;
    sel_res_t         res_reg;
    logic             hit;

    // quotients only shrink along the list, so the first one <= 256 decides
    assign hit      = (cand_reg <= Q_MAX);
    assign cand_dec = cand_reg - 1'b1;

    always_comb
    begin
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (hit || idx_reg == IDX_LAST))
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cand_reg <= q_fast;
            qc_reg   <= q_cpu;
            idx_reg  <= IDX_FAST;
            res_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                res_reg.ok  <= (cand_reg != '0);
                res_reg.idx <= idx_reg;
                res_reg.top <= cand_dec[TOP_W-1:0];
            end
            else if (idx_reg == IDX_LAST)
            begin
                res_reg.ok <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == IDX_HALF)
                begin
                    cand_reg <= Q64_W'(qc_reg);
                end
                else
                begin
                    cand_reg <= cand_reg >> 1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire
